/* hw/rtl/tlbpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types for the TLB / page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TLB,
    ST_PT,
    ST_FRAME,
    ST_LINK,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture the incoming address
    logic tlb_look;    // register TLB match result
    logic pt_read;     // register page table read data, pick the frame
    logic frame_pick;  // drop evicted mappings, pick the TLB fill slot
    logic link;        // unlink the frame from the LRU list
    logic update;      // write tables, ranks and the list head
    logic out_load;    // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic list_move;   // frame must be unlinked before moving to the head
  } status_t;

endpackage

/* hw/rtl/tlbpt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_ram
// Simple dual port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/tlbpt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer for one translation.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tlbpt_pkg::status_t sts,
  output tlbpt_pkg::cmd_t    cmd
);
  import tlbpt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_TLB;
      ST_TLB:    state_next = ST_PT;
      ST_PT:     state_next = ST_FRAME;
      ST_FRAME:  state_next = sts.list_move ? ST_LINK : ST_UPDATE;
      ST_LINK:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // out_valid is a register so results persist while the next word runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE:   begin in_ready = 1'b1; cmd.load = in_valid; end
      ST_TLB:    cmd.tlb_look = 1'b1;
      ST_PT:     cmd.pt_read = 1'b1;
      ST_FRAME:  cmd.frame_pick = 1'b1;
      ST_LINK:   cmd.link = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_OUT:    cmd.out_load = !out_valid || out_ready;
      default:   ;
    endcase
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("more than one command");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_TLB) else $error("bad accept");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule

/* hw/rtl/tlbpt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB, page table, frame tables and LRU order.
// ----------------------------------------------------------------------------
module tlbpt_datapath #(
  parameter int PAGE_COUNT  = 256,
  parameter int PAGE_BYTES  = 256,
  parameter int TLB_ENTRIES = 16,
  parameter int FRAME_COUNT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  tlbpt_pkg::cmd_t    cmd,
  output tlbpt_pkg::status_t sts,
  input  logic [15:0]        virtual_address,
  output logic [14:0]        physical_address,
  output logic               tlb_hit,
  output logic               page_fault,
  output logic [7:0]         fill_page,
  output logic [6:0]         fill_frame,
  output logic               frame_evicted,
  output logic [7:0]         evicted_page
);
  import tlbpt_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int TW = $clog2(TLB_ENTRIES);
  localparam int FW = $clog2(FRAME_COUNT);
  localparam int CW = $clog2(FRAME_COUNT + 1);

  logic [15:0] va;
  logic [PW-1:0] page;
  logic [OW-1:0] offset;
  logic [15:0] va_page;

  assign va_page = va >> OW;
  assign page    = va_page[PW-1:0];
  assign offset  = va[OW-1:0];

  // TLB in flip-flops
  logic          tlb_valid [TLB_ENTRIES];
  logic [PW-1:0] tlb_tag   [TLB_ENTRIES];
  logic [FW-1:0] tlb_frame [TLB_ENTRIES];
  logic [TW-1:0] tlb_rank  [TLB_ENTRIES];

  // page valid bits, read through a register
  logic          page_valid [PAGE_COUNT];
  logic          pv_r;
  logic [CW-1:0] frames_in_use;

  // frame LRU order as a linked list: head most recent, tail is the victim
  logic [FW-1:0] head, tail;

  logic          hit_r;
  logic [TW-1:0] slot;
  logic [FW-1:0] frame;
  logic          fault_r, evict_r;
  logic [PW-1:0] old_page;

  // memories
  logic [FW-1:0] pf_rdata;
  logic [PW-1:0] own_rdata;
  logic [FW-1:0] nxt_rdata, prv_rdata;
  logic          nxt_we, prv_we;
  logic [FW-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
  logic          ins_new, list_empty, mtf_we;

  tlbpt_ram #(.WIDTH(FW), .DEPTH(PAGE_COUNT)) u_page_frame (
    .clk(clk), .we(cmd.update && fault_r), .waddr(page), .wdata(frame),
    .raddr(page), .rdata(pf_rdata));

  tlbpt_ram #(.WIDTH(PW), .DEPTH(FRAME_COUNT)) u_owner (
    .clk(clk), .we(cmd.update && fault_r), .waddr(frame), .wdata(page),
    .raddr(tail), .rdata(own_rdata));

  // next: toward the tail, prev: toward the head
  tlbpt_ram #(.WIDTH(FW), .DEPTH(FRAME_COUNT)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(frame), .rdata(nxt_rdata));

  tlbpt_ram #(.WIDTH(FW), .DEPTH(FRAME_COUNT)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(frame), .rdata(prv_rdata));

  // link step: next[p] = n, prev[n] = p (skipped when the frame is the tail)
  // update step: next[f] = head, prev[head] = f, head = f
  assign ins_new    = fault_r && !evict_r;
  assign list_empty = frames_in_use == '0;
  assign mtf_we     = cmd.update && !(ins_new && list_empty) && (ins_new || frame != head);
  assign nxt_we     = cmd.link || mtf_we;
  assign nxt_waddr  = cmd.link ? prv_rdata : frame;
  assign nxt_wdata  = cmd.link ? nxt_rdata : head;
  assign prv_we     = (cmd.link && frame != tail) || mtf_we;
  assign prv_waddr  = cmd.link ? nxt_rdata : head;
  assign prv_wdata  = cmd.link ? prv_rdata : frame;

  assign sts.list_move = (frame != head) && (!fault_r || evict_r);

  // TLB match, lowest index wins
  logic          m_found;
  logic [TW-1:0] m_slot;
  always_comb begin
    m_found = 1'b0;
    m_slot  = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_tag[i] == page) begin
        m_found = 1'b1;
        m_slot  = TW'(i);
      end
    end
  end

  // TLB fill slot: lowest invalid after the eviction drop, else highest rank
  logic          inv_found;
  logic [TW-1:0] inv_slot, lru_slot;
  always_comb begin
    inv_found = 1'b0;
    inv_slot  = '0;
    lru_slot  = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (!tlb_valid[i] || (evict_r && tlb_tag[i] == old_page)) begin
        inv_found = 1'b1;
        inv_slot  = TW'(i);
      end
      if (tlb_rank[i] == TW'(TLB_ENTRIES - 1)) lru_slot = TW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) va <= virtual_address;
    if (cmd.tlb_look) begin
      hit_r    <= m_found;
      slot     <= m_slot;
      frame    <= tlb_frame[m_slot];
      pv_r     <= page_valid[page];
      fault_r  <= 1'b0;
      evict_r  <= 1'b0;
      old_page <= '0;
    end
    if (cmd.pt_read && !hit_r) begin
      if (pv_r) begin
        frame <= pf_rdata;
      end else begin
        fault_r <= 1'b1;
        if (frames_in_use == CW'(FRAME_COUNT)) begin
          frame    <= tail;
          evict_r  <= 1'b1;
          old_page <= own_rdata;
        end else begin
          frame <= frames_in_use[FW-1:0];
        end
      end
    end
    if (cmd.frame_pick && !hit_r) slot <= inv_found ? inv_slot : lru_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= '0;
      head <= '0;
      tail <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid[i] <= 1'b0;
        tlb_rank[i]  <= TW'(i);
      end
      for (int i = 0; i < PAGE_COUNT; i++) page_valid[i] <= 1'b0;
    end else begin
      if (cmd.frame_pick && evict_r) begin
        page_valid[old_page] <= 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tlb_valid[i] && tlb_tag[i] == old_page) tlb_valid[i] <= 1'b0;
        end
      end
      if (cmd.update) begin
        if (fault_r) begin
          page_valid[page] <= 1'b1;
          if (!evict_r) frames_in_use <= frames_in_use + CW'(1);
        end
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (TW'(i) == slot) tlb_rank[i] <= '0;
          else if (tlb_rank[i] < tlb_rank[slot]) tlb_rank[i] <= tlb_rank[i] + TW'(1);
        end
        if (!hit_r) begin
          tlb_valid[slot] <= 1'b1;
          tlb_tag[slot]   <= page;
          tlb_frame[slot] <= frame;
        end
        if (ins_new && list_empty) begin
          head <= frame;
          tail <= frame;
        end else if (mtf_we) begin
          head <= frame;
          if (!ins_new && frame == tail) tail <= prv_rdata;
        end
      end
    end
  end

  logic [31:0] pa_full;
  assign pa_full = 32'(frame) * 32'(PAGE_BYTES) + 32'(offset);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      physical_address <= pa_full[14:0];
      tlb_hit          <= hit_r;
      page_fault       <= fault_r;
      fill_page        <= fault_r ? 8'(page) : 8'd0;
      fill_frame       <= fault_r ? 7'(frame) : 7'd0;
      frame_evicted    <= evict_r;
      evicted_page     <= 8'(old_page);
    end
  end

`ifndef SYNTHESIS
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && evict_r) |-> frames_in_use == CW'(FRAME_COUNT))
    else $error("evict when not full");
  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !(hit_r && fault_r)) else $error("hit and fault");
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    frames_in_use <= CW'(FRAME_COUNT)) else $error("frame count overflow");
  a_link_not_head: assert property (@(posedge clk) disable iff (rst)
    cmd.link |-> frame != head) else $error("unlink of list head");
`endif
endmodule

/* hw/rtl/tlb_page_table_translator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical translation with TLB, page table and LRU paging.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one virtual_address word (valid/ready).
//   Output channel carries one result word per input: physical address,
//   TLB hit, page fault with fill page/frame, and eviction report.
//   Each word passes the TLB, page table, frame pick, link, update and output
//   steps in that order; the link step unlinks the frame from the LRU list and
//   is skipped when the frame is already the most recent one or a fault takes a free frame.
//   One word is in flight at a time; the next is accepted the cycle after the
//   result register loads. A waiting result does not block the next lookup.
//   Reset (rst, synchronous) empties the TLB and page table and frees all
//   frames; no clearing pass is needed.
//   A stalled receiver holds the result; the block finishes its current
//   word and waits in its output step until the result register frees.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int PAGE_COUNT  = 256,
  parameter int PAGE_BYTES  = 256,
  parameter int TLB_ENTRIES = 16,
  parameter int FRAME_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] virtual_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] physical_address,
  output logic        tlb_hit,
  output logic        page_fault,
  output logic [7:0]  fill_page,
  output logic [6:0]  fill_frame,
  output logic        frame_evicted,
  output logic [7:0]  evicted_page
);
  import tlbpt_pkg::*;

  cmd_t    cmd;
  status_t sts;

  tlbpt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

  tlbpt_datapath #(
    .PAGE_COUNT(PAGE_COUNT), .PAGE_BYTES(PAGE_BYTES),
    .TLB_ENTRIES(TLB_ENTRIES), .FRAME_COUNT(FRAME_COUNT)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .virtual_address(virtual_address), .physical_address(physical_address),
    .tlb_hit(tlb_hit), .page_fault(page_fault), .fill_page(fill_page),
    .fill_frame(fill_frame), .frame_evicted(frame_evicted),
    .evicted_page(evicted_page));
endmodule

/* bench/tb_tlb_page_table_translator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlb_page_table_translator
// Self-checking bench for the TLB / page table translator.
// Drives virtual address words through valid/ready with random idle bursts on
// both sides. A behavioral model of the TLB, the page table and both LRU
// orders predicts every result word, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translator;

  localparam int NPAGE  = 256;
  localparam int NTLB   = 16;
  localparam int NFRAME = 128;

  typedef struct packed {
    logic [14:0] pa;
    logic        hit;
    logic        fault;
    logic [7:0]  fpage;
    logic [6:0]  fframe;
    logic        evict;
    logic [7:0]  epage;
  } xlate_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] virtual_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [14:0] physical_address;
  logic        tlb_hit;
  logic        page_fault;
  logic [7:0]  fill_page;
  logic [6:0]  fill_frame;
  logic        frame_evicted;
  logic [7:0]  evicted_page;

  tlb_page_table_translator DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic       tv [NTLB];
  logic [7:0] ttag [NTLB];
  logic [6:0] tfrm [NTLB];
  int         trank [NTLB];
  logic       pv [NPAGE];
  logic [6:0] pfrm [NPAGE];
  logic [7:0] fown [NFRAME];
  int         frank [NFRAME];
  int         used;

  xlate_t expected_q[$];
  int     errors = 0;
  int     n_words = 0, n_hits = 0, n_faults = 0, n_evicts = 0;
  int     stall_left = 0;
  bit     quiet = 1'b0;

  function automatic xlate_t translate(logic [15:0] va);
    xlate_t     r;
    logic [7:0] pg;
    int         slot, f, r0;
    bit         found;
    pg = va[15:8];
    r = '0;
    found = 1'b0;
    slot = 0;
    for (int i = 0; i < NTLB; i++)
      if (!found && tv[i] && ttag[i] == pg) begin
        found = 1'b1;
        slot = i;
      end
    if (found) begin
      r.hit = 1'b1;
      f = int'(tfrm[slot]);
    end else begin
      if (pv[pg]) begin
        f = int'(pfrm[pg]);
      end else begin
        r.fault = 1'b1;
        if (used < NFRAME) begin
          f = used;
          used++;
        end else begin
          f = 0;
          for (int i = 1; i < NFRAME; i++)
            if (frank[i] > frank[f]) f = i;
          r.evict = 1'b1;
          r.epage = fown[f];
          pv[fown[f]] = 1'b0;
          for (int i = 0; i < NTLB; i++)
            if (tv[i] && ttag[i] == fown[f]) tv[i] = 1'b0;
        end
        pv[pg] = 1'b1;
        pfrm[pg] = 7'(f);
        fown[f] = pg;
        r.fpage = pg;
        r.fframe = 7'(f);
      end
      // TLB fill: first free slot, else the LRU one
      slot = -1;
      for (int i = 0; i < NTLB; i++)
        if (slot < 0 && !tv[i]) slot = i;
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < NTLB; i++)
          if (trank[i] > trank[slot]) slot = i;
      end
      tv[slot] = 1'b1;
      ttag[slot] = pg;
      tfrm[slot] = 7'(f);
    end
    r0 = trank[slot];
    for (int i = 0; i < NTLB; i++)
      if (trank[i] < r0) trank[i]++;
    trank[slot] = 0;
    r0 = frank[f];
    for (int i = 0; i < NFRAME; i++)
      if (frank[i] < r0) frank[i]++;
    frank[f] = 0;
    r.pa = {f[6:0], va[7:0]};
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  // sender: one word, optional idle burst before it; valid stays up between
  // back-to-back words
  task automatic send_word(logic [15:0] va);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    virtual_address <= va;
    expected_q.push_back(translate(va));
    n_words++;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= int'($urandom_range(0, 3));
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    xlate_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", int'(physical_address), 0);
      end else begin
        w = expected_q.pop_front();
        if (w.hit) n_hits++;
        if (w.fault) n_faults++;
        if (w.evict) n_evicts++;
        if (physical_address !== w.pa)
          report_mismatch("physical_address", int'(physical_address), int'(w.pa));
        if (tlb_hit !== w.hit) report_mismatch("tlb_hit", int'(tlb_hit), int'(w.hit));
        if (page_fault !== w.fault)
          report_mismatch("page_fault", int'(page_fault), int'(w.fault));
        if (fill_page !== w.fpage)
          report_mismatch("fill_page", int'(fill_page), int'(w.fpage));
        if (fill_frame !== w.fframe)
          report_mismatch("fill_frame", int'(fill_frame), int'(w.fframe));
        if (frame_evicted !== w.evict)
          report_mismatch("frame_evicted", int'(frame_evicted), int'(w.evict));
        if (evicted_page !== w.epage)
          report_mismatch("evicted_page", int'(evicted_page), int'(w.epage));
      end
    end
  end

  // extremes: page/offset corners, TLB hit, page-table hit after TLB refill
  task automatic test_directed();
    send_word(16'h0000);
    send_word(16'h00FF);
    send_word(16'hFFFF);
    send_word(16'hFF00);
    send_word(16'h8001);
    send_word(16'h0000);
    send_word(16'h7F80);
    // 17 distinct pages push page 0 out of the TLB; next access hits the page table
    for (int p = 1; p <= 17; p++) send_word({8'(p), 8'h55});
    send_word(16'h0042);
  endtask

  // fill all frames then keep faulting so LRU frames get evicted
  task automatic test_eviction();
    for (int p = 18; p < 200; p++) send_word({8'(p), 8'($urandom)});
    send_word(16'h0000);
    send_word(16'hFF12);
  endtask

  // half the words from a small working set for hits, the rest wide for faults
  task automatic test_random(int n);
    logic [15:0] va;
    for (int i = 0; i < n; i++) begin
      if (i > n - 150) quiet = 1'b1;
      case ($urandom_range(0, 3))
        0:       va = {8'($urandom_range(0, 7)), 8'($urandom)};
        1:       va = {8'($urandom_range(0, 40)), 8'($urandom)};
        default: va = 16'($urandom);
      endcase
      send_word(va);
    end
  endtask

  initial begin
    for (int i = 0; i < NTLB; i++) begin
      tv[i] = 1'b0; ttag[i] = '0; tfrm[i] = '0; trank[i] = i;
    end
    for (int i = 0; i < NPAGE; i++) begin
      pv[i] = 1'b0; pfrm[i] = '0;
    end
    for (int i = 0; i < NFRAME; i++) begin
      fown[i] = '0; frank[i] = i;
    end
    used = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_eviction();
    test_random(1800);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d words: %0d TLB hits, %0d faults, %0d evictions",
             n_words, n_hits, n_faults, n_evicts);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
